// ----- rtl/wscc_pkg.sv -----
// ============================================================================
// wscc_pkg: shared types and constants for the wheel speed / cadence block
// Item layouts, register map, state encodings and the per-channel decision
// function used when a measure item is accepted.
// ============================================================================
package wscc_pkg;

    localparam int REV_W   = 16;
    localparam int COEF_W  = 24;
    localparam int LIMIT_W = 16;
    localparam int PROD_W  = COEF_W + REV_W;
    localparam int CNT_W   = 6;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(REV_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W - 1);

    localparam logic [COEF_W-1:0]  SPEED_COEF_RST   = 24'd7630848;
    localparam logic [COEF_W-1:0]  CADENCE_COEF_RST = 24'd61440;
    localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RST  = 16'd150;
    localparam logic [LIMIT_W-1:0] CADENCE_LIMIT_RST = 16'd200;

    localparam logic CMD_MEASURE = 1'b0;
    localparam logic CMD_CLEAR   = 1'b1;

    localparam logic [1:0] REG_SPEED_COEF    = 2'd0;
    localparam logic [1:0] REG_CADENCE_COEF  = 2'd1;
    localparam logic [1:0] REG_SPEED_LIMIT   = 2'd2;
    localparam logic [1:0] REG_CADENCE_LIMIT = 2'd3;

    typedef struct packed {
        logic             command;
        logic [REV_W-1:0] wheel_revs;
        logic [REV_W-1:0] wheel_time;
        logic [REV_W-1:0] crank_revs;
        logic [REV_W-1:0] crank_time;
    } meas_item_t;

    typedef struct packed {
        logic [REV_W-1:0] speed;
        logic [REV_W-1:0] cadence;
        logic             zero_interval;
    } res_item_t;

    typedef struct packed {
        logic [COEF_W-1:0]  coeff;
        logic [REV_W-1:0]   drev;
        logic [REV_W-1:0]   dtime;
        logic [LIMIT_W-1:0] limit;
    } chan_op_t;

    typedef struct packed {
        logic             run;
        logic             zero;
        logic             upd;
        logic [REV_W-1:0] drev;
        logic [REV_W-1:0] dtime;
    } chan_eval_t;

    typedef enum logic [1:0] {
        U_IDLE,
        U_MUL,
        U_DIV,
        U_FIN
    } unit_state_t;

    typedef enum logic [1:0] {
        T_IDLE,
        T_CALC,
        T_OUT
    } top_state_t;

    // Decides what one channel does with a measure sample.
    function automatic chan_eval_t chan_eval(
        input logic             primed,
        input logic [REV_W-1:0] last_revs,
        input logic [REV_W-1:0] last_time,
        input logic [REV_W-1:0] revs,
        input logic [REV_W-1:0] tim
    );
        chan_eval_t ev;
        ev       = '0;
        ev.drev  = revs - last_revs;
        ev.dtime = tim - last_time;
        if (!primed) begin
            ev.upd = 1'b1;
        end else if (revs != last_revs) begin
            ev.upd = 1'b1;
            if (ev.dtime == '0) begin
                ev.zero = 1'b1;
            end else begin
                ev.run = 1'b1;
            end
        end
        return ev;
    endfunction

endpackage

// ----- rtl/wscc_chan_unit.sv -----
// ============================================================================
// wscc_chan_unit: bit-serial rate calculator for one channel
// Forms coeff * drev by shift and add, one multiplier bit per cycle, then
// divides the 40-bit product by dtime with a restoring divider, one quotient
// bit per cycle, and clamps quotients above the limit to zero.
// ============================================================================
module wscc_chan_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  wscc_pkg::chan_op_t                op,
    output logic                              busy,
    output logic [wscc_pkg::REV_W-1:0]        result
);
    import wscc_pkg::*;

    unit_state_t        state_reg, state_next;
    chan_op_t           op_reg, op_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [COEF_W-1:0]  acc_reg, acc_next;
    logic [REV_W-1:0]   mplr_reg, mplr_next;
    logic [PROD_W-1:0]  quo_reg, quo_next;
    logic [REV_W-1:0]   rem_reg, rem_next;
    logic [REV_W-1:0]   result_reg, result_next;

    logic [COEF_W-1:0]  addend;
    logic [COEF_W:0]    sum;
    logic [REV_W:0]     trial;
    logic [REV_W:0]     diff;
    logic               qbit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        op_reg     <= op_next;
        acc_reg    <= acc_next;
        mplr_reg   <= mplr_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        result_reg <= result_next;
    end

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mplr_next   = mplr_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        result_next = result_reg;

        addend = mplr_reg[0] ? op_reg.coeff : '0;
        sum    = {1'b0, acc_reg} + {1'b0, addend};
        // The partial remainder always stays below dtime, so a borrow out of
        // the 17-bit difference means the trial value was too small.
        trial  = {rem_reg, quo_reg[PROD_W-1]};
        diff   = trial - {1'b0, op_reg.dtime};
        qbit   = !diff[REV_W];

        case (state_reg)
            U_IDLE: begin
                if (start) begin
                    op_next    = op;
                    acc_next   = '0;
                    mplr_next  = op.drev;
                    cnt_next   = '0;
                    state_next = U_MUL;
                end
            end
            U_MUL: begin
                acc_next  = sum[COEF_W:1];
                mplr_next = {sum[0], mplr_reg[REV_W-1:1]};
                if (cnt_reg == MUL_LAST) begin
                    quo_next   = {sum[COEF_W:1], sum[0], mplr_reg[REV_W-1:1]};
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = U_DIV;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            U_DIV: begin
                rem_next = qbit ? diff[REV_W-1:0] : trial[REV_W-1:0];
                quo_next = {quo_reg[PROD_W-2:0], qbit};
                if (cnt_reg == DIV_LAST) begin
                    cnt_next   = '0;
                    state_next = U_FIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            U_FIN: begin
                if ((quo_reg[PROD_W-1:REV_W] != '0) ||
                    (quo_reg[REV_W-1:0] > op_reg.limit)) begin
                    result_next = '0;
                end else begin
                    result_next = quo_reg[REV_W-1:0];
                end
                state_next = U_IDLE;
            end
            default: begin
                state_next = U_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != U_IDLE);
    assign result = result_reg;

endmodule

// ----- rtl/wheel_speed_cadence_calc.sv -----
// ============================================================================
// wheel_speed_cadence_calc: wheel speed and crank cadence calculator
// Turns wrapping revolution counts and event times into speed and cadence,
// with per-channel priming, limits and an APB register port for the scales.
// ============================================================================
// Sequence: an item that needs a division passes through the channel units
// (16 multiply bits, then 40 quotient bits, then the clamp step) and then
// through T_CALC and T_OUT to the result register; clear, priming,
// zero-interval and unchanged items go from T_IDLE straight to T_OUT.
// A new item is accepted only in T_IDLE, once the previous one is through
// the channel units and handed over; the next item is accepted while the
// previous result waits in m_item. Reset (aresetn, synchronous, active low)
// restores the register defaults and leaves both channels unprimed.
module wheel_speed_cadence_calc (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Measure / clear items
    input  logic                              s_valid,
    output logic                              s_ready,
    input  wscc_pkg::meas_item_t              s_item,
    // Result items
    output logic                              m_valid,
    input  logic                              m_ready,
    output wscc_pkg::res_item_t               m_item,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wscc_pkg::PADDR_W-1:0]      paddr,
    input  logic [wscc_pkg::PDATA_W-1:0]      pwdata,
    output logic [wscc_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);
    import wscc_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. Each register sits at byte address 4*index;
    // the two low address bits are ignored.
    // ------------------------------------------------------------------
    logic [COEF_W-1:0]  speed_coef_reg;
    logic [COEF_W-1:0]  cadence_coef_reg;
    logic [LIMIT_W-1:0] speed_limit_reg;
    logic [LIMIT_W-1:0] cadence_limit_reg;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_coef_reg    <= SPEED_COEF_RST;
            cadence_coef_reg  <= CADENCE_COEF_RST;
            speed_limit_reg   <= SPEED_LIMIT_RST;
            cadence_limit_reg <= CADENCE_LIMIT_RST;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_SPEED_COEF:    speed_coef_reg    <= pwdata[COEF_W-1:0];
                REG_CADENCE_COEF:  cadence_coef_reg  <= pwdata[COEF_W-1:0];
                REG_SPEED_LIMIT:   speed_limit_reg   <= pwdata[LIMIT_W-1:0];
                REG_CADENCE_LIMIT: cadence_limit_reg <= pwdata[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SPEED_COEF:    prdata = PDATA_W'(speed_coef_reg);
            REG_CADENCE_COEF:  prdata = PDATA_W'(cadence_coef_reg);
            REG_SPEED_LIMIT:   prdata = PDATA_W'(speed_limit_reg);
            REG_CADENCE_LIMIT: prdata = PDATA_W'(cadence_limit_reg);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Channel history. Each channel remembers whether it has been primed
    // and the count and time of the last sample that primed it or moved its count.
    // ------------------------------------------------------------------
    logic             wheel_primed_reg, wheel_primed_next;
    logic [REV_W-1:0] wheel_last_revs_reg, wheel_last_revs_next;
    logic [REV_W-1:0] wheel_last_time_reg, wheel_last_time_next;
    logic             crank_primed_reg, crank_primed_next;
    logic [REV_W-1:0] crank_last_revs_reg, crank_last_revs_next;
    logic [REV_W-1:0] crank_last_time_reg, crank_last_time_next;

    // Sequencing and the result register.
    top_state_t       state_reg, state_next;
    logic             wrun_reg, wrun_next;
    logic             crun_reg, crun_next;
    logic             zero_reg, zero_next;
    logic             m_valid_reg, m_valid_next;
    res_item_t        m_item_reg, m_item_next;

    chan_eval_t       wev;
    chan_eval_t       cev;
    logic             accept;
    logic             is_meas;
    logic             wstart;
    logic             cstart;
    chan_op_t         wop;
    chan_op_t         cop;
    logic             wbusy;
    logic             cbusy;
    logic [REV_W-1:0] wresult;
    logic [REV_W-1:0] cresult;

    // Both channels are judged straight from the accepted item and the
    // stored history, so only the multiply and division need the serial units.
    assign wev = chan_eval(wheel_primed_reg, wheel_last_revs_reg, wheel_last_time_reg,
                           s_item.wheel_revs, s_item.wheel_time);
    assign cev = chan_eval(crank_primed_reg, crank_last_revs_reg, crank_last_time_reg,
                           s_item.crank_revs, s_item.crank_time);

    assign s_ready = (state_reg == T_IDLE);
    assign accept  = s_valid && s_ready;
    assign is_meas = (s_item.command == CMD_MEASURE);
    assign wstart  = accept && is_meas && wev.run;
    assign cstart  = accept && is_meas && cev.run;

    assign wop = '{coeff: speed_coef_reg, drev: wev.drev, dtime: wev.dtime,
                   limit: speed_limit_reg};
    assign cop = '{coeff: cadence_coef_reg, drev: cev.drev, dtime: cev.dtime,
                   limit: cadence_limit_reg};

    // The two channels run side by side, each in its own serial unit.
    wscc_chan_unit u_wheel (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (wstart),
        .op      (wop),
        .busy    (wbusy),
        .result  (wresult)
    );

    wscc_chan_unit u_crank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cstart),
        .op      (cop),
        .busy    (cbusy),
        .result  (cresult)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= T_IDLE;
            m_valid_reg         <= 1'b0;
            wheel_primed_reg    <= 1'b0;
            wheel_last_revs_reg <= '0;
            wheel_last_time_reg <= '0;
            crank_primed_reg    <= 1'b0;
            crank_last_revs_reg <= '0;
            crank_last_time_reg <= '0;
        end else begin
            state_reg           <= state_next;
            m_valid_reg         <= m_valid_next;
            wheel_primed_reg    <= wheel_primed_next;
            wheel_last_revs_reg <= wheel_last_revs_next;
            wheel_last_time_reg <= wheel_last_time_next;
            crank_primed_reg    <= crank_primed_next;
            crank_last_revs_reg <= crank_last_revs_next;
            crank_last_time_reg <= crank_last_time_next;
        end
        wrun_reg   <= wrun_next;
        crun_reg   <= crun_next;
        zero_reg   <= zero_next;
        m_item_reg <= m_item_next;
    end

    always_comb begin
        state_next           = state_reg;
        wrun_next            = wrun_reg;
        crun_next            = crun_reg;
        zero_next            = zero_reg;
        m_item_next          = m_item_reg;
        wheel_primed_next    = wheel_primed_reg;
        wheel_last_revs_next = wheel_last_revs_reg;
        wheel_last_time_next = wheel_last_time_reg;
        crank_primed_next    = crank_primed_reg;
        crank_last_revs_next = crank_last_revs_reg;
        crank_last_time_next = crank_last_time_reg;
        // The result register empties when the consumer takes its item.
        m_valid_next         = m_valid_reg && !m_ready;

        case (state_reg)
            T_IDLE: begin
                if (accept) begin
                    if (is_meas) begin
                        wrun_next = wev.run;
                        crun_next = cev.run;
                        zero_next = wev.zero || cev.zero;
                        if (wev.upd) begin
                            wheel_primed_next    = 1'b1;
                            wheel_last_revs_next = s_item.wheel_revs;
                            wheel_last_time_next = s_item.wheel_time;
                        end
                        if (cev.upd) begin
                            crank_primed_next    = 1'b1;
                            crank_last_revs_next = s_item.crank_revs;
                            crank_last_time_next = s_item.crank_time;
                        end
                        state_next = (wev.run || cev.run) ? T_CALC : T_OUT;
                    end else begin
                        // A clear item unprimes both channels and reports zeros.
                        wrun_next         = 1'b0;
                        crun_next         = 1'b0;
                        zero_next         = 1'b0;
                        wheel_primed_next = 1'b0;
                        crank_primed_next = 1'b0;
                        state_next        = T_OUT;
                    end
                end
            end
            T_CALC: begin
                if (!wbusy && !cbusy) begin
                    state_next = T_OUT;
                end
            end
            T_OUT: begin
                // Hand the result over once the output register is free or
                // is being emptied in this same cycle.
                if (!m_valid_reg || m_ready) begin
                    m_item_next.speed         = wrun_reg ? wresult : '0;
                    m_item_next.cadence       = crun_reg ? cresult : '0;
                    m_item_next.zero_interval = zero_reg;
                    m_valid_next              = 1'b1;
                    state_next                = T_IDLE;
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule
